// File: sv/fbf_pkg.sv
`timescale 1ns / 1ps

package fbf_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned ROM_LEN  = 31;
    localparam int unsigned FRAC_W   = 15;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [SAMPLE_W+COEF_W-1:0] t_prod;

    // 25-450 Hz band-pass kernel, Q1.15, symmetric about tap 15
    localparam t_coef COEF_ROM [ROM_LEN] = '{
        -16'sd95,   16'sd10,    -16'sd163,  -16'sd53,   -16'sd285,  -16'sd323,
        -16'sd312,  -16'sd985,  -16'sd72,   -16'sd2082, 16'sd469,   -16'sd3394,
        16'sd1123,  -16'sd4481, 16'sd1572,  16'sd27789, 16'sd1572,  -16'sd4481,
        16'sd1123,  -16'sd3394, 16'sd469,   -16'sd2082, -16'sd72,   -16'sd985,
        -16'sd312,  -16'sd323,  -16'sd285,  -16'sd53,   -16'sd163,  16'sd10,
        -16'sd95
    };

    // taps past the end of the table carry a zero coefficient
    function automatic t_coef coef_at(input logic [31:0] idx);
        t_coef c;
        c = '0;
        if (idx < 32'(ROM_LEN)) begin
            c = COEF_ROM[idx[4:0]];
        end
        return c;
    endfunction

endpackage

// File: sv/fir_bandpass_filter_unit.sv
`timescale 1ns / 1ps

// Band-pass FIR filter, direct form, fixed Q1.15 kernel (25-450 Hz).
//
// Input channel : i_sample with i_valid / o_ready. A transaction takes place
//                 on a rising edge with both high.
// Output channel: o_filtered with o_valid / i_ready, one result per input.
//
// The delay line is a rotating shift register. After a sample is taken in,
// the line turns by one sample per cycle, so tap 0 always sits under a single
// shared 16x16 multiplier; product and accumulate stages follow it.
// One item is in flight at a time: a new sample is taken only once the single
// multiply-accumulate has swept every tap and its sum has been handed over.
//
// The result waits in its own output register, so a new sample is taken as
// soon as the filter has handed its sum over, even while the receiver stalls;
// a finished sum is held until that register is free.
//
// Reset (i_rst_n low, synchronous) clears the delay line to zero, so early
// outputs see zeros in the older taps, and empties the pipeline and output.
module fir_bandpass_filter_unit
    import fbf_pkg::*;
#(
    parameter int unsigned TAPS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_filtered
);

    localparam int unsigned CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int unsigned ACC_W = SAMPLE_W + COEF_W + CNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

    logic [1:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt;
    t_sample                r_dl [TAPS];

    // stage 1: coefficient and tap, stage 2: product
    logic                   r_s1_vld, r_s1_last;
    t_coef                  r_c;
    t_sample                r_x;
    logic                   r_s2_vld, r_s2_last;
    t_prod                  r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic                   r_out_vld;
    t_sample                r_out;

    logic                   in_txn;
    logic                   out_free;
    logic                   last_tap;
    logic signed [ACC_W-1:0] shifted;
    t_sample                sat_val;

    assign in_txn   = i_valid && o_ready;
    assign out_free = !r_out_vld || i_ready;
    assign last_tap = (r_cnt == CNT_W'(TAPS - 1));
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_filtered = r_out;

    // arithmetic shift floors, as required
    assign shifted = r_acc >>> FRAC_W;

    always_comb begin
        if (shifted > SAT_HI) begin
            sat_val = 16'sh7fff;
        end else if (shifted < SAT_LO) begin
            sat_val = 16'sh8000;
        end else begin
            sat_val = shifted[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_txn) n_state = S_RUN;
            end
            S_RUN: begin
                if (last_tap) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (r_s2_vld && r_s2_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                r_dl[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            // delay line: insert on transaction, rotate once per tap
            if (in_txn) begin
                r_dl[0] <= i_sample;
                for (int k = 1; k < TAPS; k++) begin
                    r_dl[k] <= r_dl[k-1];
                end
            end else if (r_state == S_RUN) begin
                r_dl[TAPS-1] <= r_dl[0];
                for (int k = 0; k < TAPS - 1; k++) begin
                    r_dl[k] <= r_dl[k+1];
                end
            end

            if (in_txn) begin
                r_cnt <= '0;
            end else if (r_state == S_RUN && !last_tap) begin
                r_cnt <= r_cnt + 1'b1;
            end

            r_s1_vld <= (r_state == S_RUN);
            r_s2_vld <= r_s1_vld;

            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_c       <= coef_at(32'(r_cnt));
        r_x       <= r_dl[0];
        r_s1_last <= last_tap;
        r_prod    <= r_c * r_x;
        r_s2_last <= r_s1_last;
        if (in_txn) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= sat_val;
        end
    end

    // pipeline holds nothing while waiting for a sample
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_vld && !r_s2_vld))
        else $error("MAC pipeline busy while idle");

    // a taken sample starts the tap sweep from tap zero
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_txn |=> (r_state == S_RUN && r_cnt == '0))
        else $error("tap sweep did not start");

    // finished sum moves into a free output register
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_valid && r_state == S_IDLE))
        else $error("result not delivered");

    // the sweep ends on the last tap
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !last_tap) |=> (r_state == S_RUN))
        else $error("sweep ended early");

endmodule
